[rtl/core/tmea_pkg.sv]
// Package for the text mark edit adjuster: field widths, command codes and the
// request token that travels down the row of mark cells. No dependencies.
package tmea_pkg;

   // Fixed widths of the stream fields.
   localparam int SLOT_W     = 4;
   localparam int FIELD_W    = 31;
   localparam int SIZE_W     = 32;
   localparam int CMD_W      = 2;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 72;

   // Command codes carried on req_tuser.
   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_EDIT  = 2'd2
   } cmd_type;

   // One request as it moves from cell to cell, together with the report of
   // the addressed slot once that slot's cell has been passed.
   typedef struct packed {
      logic                 valid;
      cmd_type              cmd;
      logic [SLOT_W-1:0]    slot;
      logic [FIELD_W-1:0]   new_start;
      logic [FIELD_W-1:0]   new_length;
      logic                 new_grow_at_start;
      logic                 new_grow_at_end;
      logic                 new_in_use;
      logic                 edit_on;
      logic                 edit_ins;
      logic [FIELD_W-1:0]   edit_pos;
      logic [SIZE_W-1:0]    edit_mag;
      logic [SIZE_W:0]      edit_end;
      logic [FIELD_W-1:0]   out_start;
      logic [FIELD_W-1:0]   out_length;
      logic                 out_modified;
      logic                 out_grow_at_start;
      logic                 out_grow_at_end;
      logic                 out_in_use;
   } token_type;

endpackage

[rtl/core/tmea_cell.sv]
// One mark cell: holds a single text mark, applies the request passing by to
// it and hands the request on to the next cell. Depends on tmea_pkg.
module tmea_cell #(
   parameter int POS_BITS   = 31,
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  tmea_pkg::token_type tok_in,
   output tmea_pkg::token_type tok_out
);
   import tmea_pkg::*;

   // Working width: holds the sum of start and length, and the deletion end.
   localparam int EW = ((POS_BITS > SIZE_W) ? POS_BITS : SIZE_W) + 2;
   localparam logic [EW-1:0] MAX_POS = (EW'(1) << POS_BITS) - EW'(1);
   localparam bit ADDRESSABLE = (CELL_INDEX < (1 << SLOT_W));
   localparam logic [SLOT_W-1:0] CELL_ID = SLOT_W'(CELL_INDEX);

   logic [POS_BITS-1:0] start_ff, start_in;
   logic [POS_BITS-1:0] length_ff, length_in;
   logic                modified_ff, modified_in;
   logic                grow_start_ff, grow_start_in;
   logic                grow_end_ff, grow_end_in;
   logic                active_ff, active_in;
   token_type           tok_ff, tok_in_nx;

   logic [EW-1:0] st_e, len_e, end_e, pos_e, mag_e, pp_e;
   logic          hit;

   // Clamp a working value to the largest position.
   function automatic logic [POS_BITS-1:0] sat_pos(input logic [EW-1:0] v);
      logic [EW-1:0] r;
      r = (v > MAX_POS) ? MAX_POS : v;
      return r[POS_BITS-1:0];
   endfunction

   // Fit a stored position into the reported field width.
   function automatic logic [FIELD_W-1:0] to_field(input logic [POS_BITS-1:0] v);
      logic [EW-1:0] t;
      t = EW'(v);
      return t[FIELD_W-1:0];
   endfunction

   assign st_e  = EW'(start_ff);
   assign len_e = EW'(length_ff);
   assign end_e = st_e + len_e;
   assign pos_e = EW'(tok_in.edit_pos);
   assign mag_e = EW'(tok_in.edit_mag);
   assign pp_e  = EW'(tok_in.edit_end);
   assign hit   = ADDRESSABLE && (tok_in.slot == CELL_ID);

   // Next mark contents for the request at this cell.
   always_comb begin
      start_in      = start_ff;
      length_in     = length_ff;
      modified_in   = modified_ff;
      grow_start_in = grow_start_ff;
      grow_end_in   = grow_end_ff;
      active_in     = active_ff;
      if (tok_in.valid) begin
         case (tok_in.cmd)
            CMD_WRITE: begin
               if (hit) begin
                  start_in      = sat_pos(EW'(tok_in.new_start));
                  length_in     = sat_pos(EW'(tok_in.new_length));
                  modified_in   = 1'b0;
                  grow_start_in = tok_in.new_grow_at_start;
                  grow_end_in   = tok_in.new_grow_at_end;
                  active_in     = tok_in.new_in_use;
               end
            end
            CMD_EDIT: begin
               if (active_ff && tok_in.edit_on && (pos_e <= end_e)) begin
                  if (tok_in.edit_ins) begin
                     // Insertion: grow at the end, shift, or grow inside.
                     if (pos_e == end_e) begin
                        if (grow_end_ff) begin
                           length_in   = sat_pos(len_e + mag_e);
                           modified_in = 1'b1;
                        end
                     end else if ((pos_e < st_e) || ((pos_e == st_e) && !grow_start_ff)) begin
                        start_in = sat_pos(st_e + mag_e);
                     end else begin
                        length_in   = sat_pos(len_e + mag_e);
                        modified_in = 1'b1;
                     end
                  end else if (pos_e < end_e) begin
                     // Deletion: shift left when wholly before, else trim.
                     if (pp_e <= st_e) begin
                        start_in = sat_pos(st_e - mag_e);
                     end else begin
                        modified_in = 1'b1;
                        if (pos_e <= st_e) begin
                           start_in  = sat_pos(pos_e);
                           length_in = (end_e > pp_e) ? sat_pos(end_e - pp_e) : '0;
                        end else begin
                           length_in = (end_e > pp_e) ? sat_pos(len_e - mag_e)
                                                      : sat_pos(pos_e - st_e);
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // The request picks up the report when it passes its own slot.
   always_comb begin
      tok_in_nx = tok_in;
      if (hit) begin
         tok_in_nx.out_start         = to_field(start_in);
         tok_in_nx.out_length        = to_field(length_in);
         tok_in_nx.out_modified      = modified_in;
         tok_in_nx.out_grow_at_start = grow_start_in;
         tok_in_nx.out_grow_at_end   = grow_end_in;
         tok_in_nx.out_in_use        = active_in;
      end
   end

   // Mark state and the stage register toward the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff      <= '0;
         length_ff     <= '0;
         modified_ff   <= 1'b0;
         grow_start_ff <= 1'b0;
         grow_end_ff   <= 1'b1;
         active_ff     <= 1'b0;
         tok_ff        <= '0;
      end else if (advance) begin
         start_ff      <= start_in;
         length_ff     <= length_in;
         modified_ff   <= modified_in;
         grow_start_ff <= grow_start_in;
         grow_end_ff   <= grow_end_in;
         active_ff     <= active_in;
         tok_ff        <= tok_in_nx;
      end
   end

   assign tok_out = tok_ff;

endmodule

[rtl/core/text_mark_edit_adjuster.sv]
// Text mark edit adjuster: a row of mark cells that a request walks through.
// Depends on tmea_pkg and tmea_cell.
//
// Usage: each request on req_* carries a command on req_tuser (write slot,
// read slot, apply edit) and its operands on req_tdata. Every request gives
// exactly one response on rsp_*, reporting the addressed slot after the
// request took effect. A request enters the first cell and moves one cell
// per cycle while the row is not held; each cell holds one mark and applies
// the request to it as the request passes, so an edit reaches all marks in
// request order. The row is a pipeline, so one request per cycle is taken
// while the receiver keeps up.
// The last cell's stage register is the response register. When the
// receiver stalls with a response waiting, the whole row holds and
// req_tready drops in the same cycle; nothing is lost or repeated.
// Reset (synchronous, active high) clears all marks to unused with zero
// start and length, grow-at-end set, and empties the row.
// Slot numbers at or above MARK_SLOTS report zero in all mark fields and a
// write to them is dropped.
module text_mark_edit_adjuster #(
   parameter int MARK_SLOTS = 16,
   parameter int POS_BITS   = 31
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // slot[3:0], new_start[34:4], new_length[65:35], new_grow_at_start[66],
   // new_grow_at_end[67], new_in_use[68], edit_pos[99:69], edit_size[131:100]
   input  logic [tmea_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd[1:0]
   input  logic [tmea_pkg::CMD_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_slot[3:0], out_start[34:4], out_length[65:35], out_modified[66],
   // out_grow_at_start[67], out_grow_at_end[68], out_in_use[69]
   output logic [tmea_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import tmea_pkg::*;

   token_type          chain [MARK_SLOTS+1];
   token_type          entry;
   token_type          last;
   logic               advance;
   logic [SIZE_W-1:0]  size;

   // The row moves whenever the response register is free or being taken.
   assign last       = chain[MARK_SLOTS];
   assign advance    = !last.valid || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = last.valid;

   // Unpack the request and precompute the edit magnitude and range end.
   assign size = req_tdata[131:100];
   always_comb begin
      entry                   = '0;
      entry.valid             = req_tvalid;
      entry.cmd               = cmd_type'(req_tuser);
      entry.slot              = req_tdata[3:0];
      entry.new_start         = req_tdata[34:4];
      entry.new_length        = req_tdata[65:35];
      entry.new_grow_at_start = req_tdata[66];
      entry.new_grow_at_end   = req_tdata[67];
      entry.new_in_use        = req_tdata[68];
      entry.edit_pos          = req_tdata[99:69];
      entry.edit_on           = (size != '0);
      entry.edit_ins          = !size[SIZE_W-1];
      entry.edit_mag          = size[SIZE_W-1] ? (~size + SIZE_W'(1)) : size;
      entry.edit_end          = (SIZE_W+1)'(req_tdata[99:69]) + {1'b0, entry.edit_mag};
   end

   assign chain[0] = entry;

   // One cell per mark slot.
   for (genvar k = 0; k < MARK_SLOTS; k++) begin : g_mark
      tmea_cell #(
         .POS_BITS   (POS_BITS),
         .CELL_INDEX (k)
      ) u_mark (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (chain[k]),
         .tok_out (chain[k+1])
      );
   end

   // Pack the response.
   assign rsp_tdata = {2'b00, last.out_in_use, last.out_grow_at_end,
                       last.out_grow_at_start, last.out_modified,
                       last.out_length, last.out_start, last.slot};

endmodule
